// ----- rtl/nfcrsp_pkg.sv -----
`timescale 1ns / 1ps

package nfcrsp_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int POS_W       = $clog2(MAX_PAYLOAD + 1);

   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 3;
   localparam int PLEN_W   = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_COMMAND_CODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HAS_STATUS   = 1'd1;

   localparam logic [BYTE_W-1:0] READY_BYTE = 8'h01;
   localparam logic [BYTE_W-1:0] PRE_BYTE   = 8'h00;
   localparam logic [BYTE_W-1:0] SC1_BYTE   = 8'h00;
   localparam logic [BYTE_W-1:0] SC2_BYTE   = 8'hFF;
   localparam logic [BYTE_W-1:0] DIR_BYTE   = 8'hD5;
   localparam logic [BYTE_W-1:0] STAT_OK    = 8'h00;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_HEADER   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LEN_SUM  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LEN_RNG  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DIR      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RESP     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_STATUS   = 3'd6;
   localparam logic [STATUS_W-1:0] ST_DATA_SUM = 3'd7;

   typedef enum logic [11:0] {
      PH_IDLE  = 12'b0000_0000_0001,
      PH_READY = 12'b0000_0000_0010,
      PH_PRE   = 12'b0000_0000_0100,
      PH_SC1   = 12'b0000_0000_1000,
      PH_SC2   = 12'b0000_0001_0000,
      PH_LEN   = 12'b0000_0010_0000,
      PH_LCS   = 12'b0000_0100_0000,
      PH_DIR   = 12'b0000_1000_0000,
      PH_RESP  = 12'b0001_0000_0000,
      PH_STAT  = 12'b0010_0000_0000,
      PH_DATA  = 12'b0100_0000_0000,
      PH_DCS   = 12'b1000_0000_0000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              frame_start;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   data_byte;
      logic [INDEX_W-1:0]  data_index;
      logic                is_verdict;
      logic [STATUS_W-1:0] status;
      logic [PLEN_W-1:0]   payload_length;
   } rsp_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] command_code;
      logic              has_status;
   } cfg_type;

endpackage

// ----- rtl/nfcrsp_if.sv -----
`timescale 1ns / 1ps

interface nfcrsp_req_if import nfcrsp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_start;

   modport source (output valid, rx_byte, frame_start, input ready);
   modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface nfcrsp_rsp_if import nfcrsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_byte;
   logic [INDEX_W-1:0]  data_index;
   logic                is_verdict;
   logic [STATUS_W-1:0] status;
   logic [PLEN_W-1:0]   payload_length;

   modport source (output valid, data_byte, data_index, is_verdict, status, payload_length,
                   input ready);
   modport sink   (input valid, data_byte, data_index, is_verdict, status, payload_length,
                   output ready);
endinterface

interface nfcrsp_csr_if import nfcrsp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/nfcrsp_core.sv -----
`timescale 1ns / 1ps

module nfcrsp_core import nfcrsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   input  cfg_type      cfg,
   output logic         emit,
   output rsp_item_type result
);

   phase_type         phase_ff, phase_in, phase_cur;
   logic [POS_W-1:0]  remaining_ff, remaining_in, remaining_cur;
   logic [POS_W-1:0]  position_ff, position_in, position_cur;
   logic [BYTE_W-1:0] sum_ff, sum_in, sum_cur;
   logic [BYTE_W-1:0] held_ff, held_in, held_cur;

   logic [BYTE_W-1:0] b;
   logic [BYTE_W-1:0] overhead;
   logic [BYTE_W:0]   resp_code;
   logic [BYTE_W-1:0] len_sum;
   logic [BYTE_W-1:0] sum_add;
   logic              len_bad;
   logic [BYTE_W-1:0] remaining_len;
   logic [POS_W-1:0]  remaining_dec;

   function automatic rsp_item_type verdict(input logic [STATUS_W-1:0] code,
                                            input logic [POS_W-1:0] count);
      rsp_item_type r;
      r                = '0;
      r.is_verdict     = 1'b1;
      r.status         = code;
      r.payload_length = PLEN_W'(count);
      return r;
   endfunction

   always_comb begin
      b             = item.rx_byte;
      phase_cur     = item.frame_start ? PH_READY : phase_ff;
      remaining_cur = item.frame_start ? '0 : remaining_ff;
      position_cur  = item.frame_start ? '0 : position_ff;
      sum_cur       = item.frame_start ? '0 : sum_ff;
      held_cur      = item.frame_start ? '0 : held_ff;

      overhead      = cfg.has_status ? 8'd3 : 8'd2;
      resp_code     = {1'b0, cfg.command_code} + 9'd1;
      len_sum       = held_cur + b;
      sum_add       = sum_cur + b;
      len_bad       = ({1'b0, held_cur} < {1'b0, overhead}) ||
                      ({1'b0, held_cur} > (9'(MAX_PAYLOAD) + {1'b0, overhead}));
      remaining_len = held_cur - overhead;
      remaining_dec = remaining_cur - POS_W'(1);

      phase_in     = phase_cur;
      remaining_in = remaining_cur;
      position_in  = position_cur;
      sum_in       = sum_cur;
      held_in      = held_cur;
      emit         = 1'b0;
      result       = '0;

      case (phase_cur)
         PH_READY, PH_PRE, PH_SC1, PH_SC2: begin
            if ((phase_cur == PH_READY && b != READY_BYTE) ||
                (phase_cur == PH_PRE   && b != PRE_BYTE)   ||
                (phase_cur == PH_SC1   && b != SC1_BYTE)   ||
                (phase_cur == PH_SC2   && b != SC2_BYTE)) begin
               emit     = 1'b1;
               result   = verdict(ST_HEADER, '0);
               phase_in = PH_IDLE;
            end else begin
               case (phase_cur)
                  PH_READY: phase_in = PH_PRE;
                  PH_PRE:   phase_in = PH_SC1;
                  PH_SC1:   phase_in = PH_SC2;
                  default:  phase_in = PH_LEN;
               endcase
            end
         end
         PH_LEN: begin
            held_in  = b;
            phase_in = PH_LCS;
         end
         PH_LCS: begin
            if (len_sum != '0) begin
               emit     = 1'b1;
               result   = verdict(ST_LEN_SUM, '0);
               phase_in = PH_IDLE;
            end else if (len_bad) begin
               emit     = 1'b1;
               result   = verdict(ST_LEN_RNG, '0);
               phase_in = PH_IDLE;
            end else begin
               remaining_in = POS_W'(remaining_len);
               phase_in     = PH_DIR;
            end
         end
         PH_DIR: begin
            if (b != DIR_BYTE) begin
               emit     = 1'b1;
               result   = verdict(ST_DIR, '0);
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_RESP;
            end
         end
         PH_RESP: begin
            if ({1'b0, b} != resp_code) begin
               emit     = 1'b1;
               result   = verdict(ST_RESP, '0);
               phase_in = PH_IDLE;
            end else begin
               sum_in = DIR_BYTE + BYTE_W'(resp_code);
               if (cfg.has_status) begin
                  phase_in = PH_STAT;
               end else begin
                  phase_in = (remaining_cur != '0) ? PH_DATA : PH_DCS;
               end
            end
         end
         PH_STAT: begin
            if (b != STAT_OK) begin
               emit     = 1'b1;
               result   = verdict(ST_STATUS, '0);
               phase_in = PH_IDLE;
            end else begin
               sum_in   = sum_add;
               phase_in = (remaining_cur != '0) ? PH_DATA : PH_DCS;
            end
         end
         PH_DATA: begin
            emit              = 1'b1;
            result.data_byte  = b;
            result.data_index = INDEX_W'(position_cur);
            sum_in            = sum_add;
            position_in       = position_cur + POS_W'(1);
            remaining_in      = remaining_dec;
            if (remaining_dec == '0) begin
               phase_in = PH_DCS;
            end
         end
         PH_DCS: begin
            emit     = 1'b1;
            result   = verdict((sum_add == '0) ? ST_OK : ST_DATA_SUM, position_cur);
            sum_in   = sum_add;
            phase_in = PH_IDLE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         remaining_ff <= '0;
         position_ff  <= '0;
         sum_ff       <= '0;
         held_ff      <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         position_ff  <= position_in;
         sum_ff       <= sum_in;
         held_ff      <= held_in;
      end
   end

endmodule

// ----- rtl/nfc_response_frame_parser.sv -----
`timescale 1ns / 1ps
// An accepted byte passes the input register, then the result register, before its result.
// Throughput: 1 byte per cycle while the response channel is not stalled; the per-byte compare
// and add sits between the two registers. A byte that yields no result still takes its slot in the input register.
// Reset (synchronous, active high): parser idle, bytes ignored until a frame start,
// both valid flags cleared (the register contents are not reset), both stages empty.

module nfc_response_frame_parser import nfcrsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   nfcrsp_req_if.sink   req_ch,
   nfcrsp_rsp_if.source rsp_ch,
   nfcrsp_csr_if.sink   csr_ch
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   cfg_type      cfg_ff, cfg_in;

   logic         advance;
   logic         emit;
   rsp_item_type result;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || advance;
   assign csr_ch.ready  = 1'b1;

   assign in_valid_in  = req_ch.valid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? emit : (out_valid_ff && !rsp_ch.ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_COMMAND_CODE: cfg_in.command_code = csr_ch.data;
            REG_HAS_STATUS:   cfg_in.has_status   = csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   nfcrsp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .emit    (emit),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_item_ff.rx_byte     <= req_ch.rx_byte;
         in_item_ff.frame_start <= req_ch.frame_start;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.data_byte      = out_item_ff.data_byte;
   assign rsp_ch.data_index     = out_item_ff.data_index;
   assign rsp_ch.is_verdict     = out_item_ff.is_verdict;
   assign rsp_ch.status         = out_item_ff.status;
   assign rsp_ch.payload_length = out_item_ff.payload_length;

`ifndef SYNTHESIS
   a_payload_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.is_verdict |-> rsp_ch.status == ST_OK &&
      rsp_ch.payload_length == '0)
      else $error("payload item carries verdict fields");

   a_verdict_data_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_verdict |-> rsp_ch.data_byte == '0 &&
      rsp_ch.data_index == '0)
      else $error("verdict carries payload fields");

   a_error_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_verdict && rsp_ch.status != ST_OK &&
      rsp_ch.status != ST_DATA_SUM |-> rsp_ch.payload_length == '0)
      else $error("early error verdict carries a length");

   a_full_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input taken while both stages are stalled");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> in_valid_ff)
      else $error("accepted byte lost before processing");
`endif

endmodule
